[hw/rtl/ffmq_pkg.sv]
package ffmq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ID_W = 16;
  localparam int SIZE_W = 8;
  localparam int OCC_W = 5;
  localparam int STAT_W = 2;
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 32;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_MATCH = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NONE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

[hw/rtl/first_fit_match_queue_top.sv]
// Ordered queue of up to DEPTH (id, size) entries with first-fit removal.
// Input channel (in_*): one request per transaction. tuser = request type
// (push or match); tdata carries entry id/size for a push, wanted size and
// free seats for a match. Output channel (out_*): exactly one result per
// request, in request order: tuser = status, tdata = removed id/size and the
// occupancy after the request.
// Sequence: a push goes from acceptance to the emit step, then to the output
// register. A match walks the entries oldest first through one shared size
// comparator, one entry per cycle, and goes to the emit step on the first hit
// or once every held entry is tried without a hit. Removal closes the gap by
// shifting the younger entries down in the same cycle.
// in_tready is high only while the sequencer is idle; one request is in work
// at a time. The next request can be taken in the cycle its predecessor's
// result goes valid, so no request is taken before the last one is done.
// A finished result sits in the output register until taken; a stalled
// receiver holds the sequencer in its emit step, so no result is ever lost.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; slot contents are not cleared since only held entries are read.
module first_fit_match_queue_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] entry_id, [23:16] entry_size, [31:24] wanted_size, [39:32] free_seats
  input  logic [ffmq_pkg::IN_DATA_W-1:0] in_tdata,
  // [0] req_type
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] found_id, [23:16] found_size, [28:24] occupancy, [31:29] zero
  output logic [ffmq_pkg::OUT_DATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [ffmq_pkg::STAT_W-1:0] out_tuser
);

  localparam int IDX_W = ffmq_pkg::IDX_W;
  localparam int CNT_W = ffmq_pkg::CNT_W;
  localparam int ID_W = ffmq_pkg::ID_W;
  localparam int SIZE_W = ffmq_pkg::SIZE_W;
  localparam int OCC_W = ffmq_pkg::OCC_W;
  localparam int STAT_W = ffmq_pkg::STAT_W;
  localparam int DEPTH = ffmq_pkg::DEPTH;

  ffmq_pkg::state_t state_r, state_nxt;

  logic [ID_W-1:0]   slot_id_r   [DEPTH];
  logic [SIZE_W-1:0] slot_size_r [DEPTH];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;

  logic [SIZE_W-1:0] wanted_r, seats_r;

  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic [SIZE_W-1:0] res_size_r, res_size_nxt;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [ID_W-1:0]   out_id_r;
  logic [SIZE_W-1:0] out_size_r;
  logic [OCC_W-1:0]  out_occ_r;

  logic              in_fire;
  logic              is_push;
  logic              full;
  logic              push_wr;
  logic              scan_end;
  logic              scan_hit;
  logic              emit_go;
  logic [SIZE_W-1:0] cur_size;
  logic [ID_W-1:0]   cur_id;
  logic [CNT_W+OCC_W-1:0] occ_ext;

  logic [ID_W-1:0]   in_entry_id;
  logic [SIZE_W-1:0] in_entry_size;
  logic [SIZE_W-1:0] in_wanted;
  logic [SIZE_W-1:0] in_seats;

  assign in_entry_id   = in_tdata[ID_W-1:0];
  assign in_entry_size = in_tdata[ID_W+SIZE_W-1:ID_W];
  assign in_wanted     = in_tdata[ID_W+2*SIZE_W-1:ID_W+SIZE_W];
  assign in_seats      = in_tdata[ID_W+3*SIZE_W-1:ID_W+2*SIZE_W];

  assign in_fire  = in_tvalid && in_tready;
  assign is_push  = (in_tuser == ffmq_pkg::REQ_PUSH);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign push_wr  = in_fire && is_push && !full;

  // shared compare unit: one entry per cycle
  assign cur_size = slot_size_r[idx_r[IDX_W-1:0]];
  assign cur_id   = slot_id_r[idx_r[IDX_W-1:0]];
  assign scan_end = (idx_r >= count_r);
  assign scan_hit = !scan_end && (cur_size <= seats_r) &&
                    ((wanted_r == '0) || (cur_size == wanted_r));
  assign emit_go  = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffmq_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = is_push ? ffmq_pkg::ST_EMIT : ffmq_pkg::ST_SCAN;
        end
      end
      ffmq_pkg::ST_SCAN: begin
        if (scan_end || scan_hit) begin
          state_nxt = ffmq_pkg::ST_EMIT;
        end
      end
      ffmq_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ffmq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ffmq_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_tready      = 1'b0;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_size_nxt   = res_size_r;
    unique case (state_r)
      ffmq_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          idx_nxt        = '0;
          res_id_nxt     = '0;
          res_size_nxt   = '0;
          res_status_nxt = ffmq_pkg::STAT_OK;
          if (is_push) begin
            if (full) begin
              res_status_nxt = ffmq_pkg::STAT_FULL;
            end else begin
              count_nxt = count_r + CNT_W'(1);
            end
          end
        end
      end
      ffmq_pkg::ST_SCAN: begin
        if (scan_end) begin
          res_status_nxt = ffmq_pkg::STAT_NONE;
        end else if (scan_hit) begin
          res_status_nxt = ffmq_pkg::STAT_OK;
          res_id_nxt     = cur_id;
          res_size_nxt   = cur_size;
          count_nxt      = count_r - CNT_W'(1);
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ffmq_pkg::ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffmq_pkg::ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (state_r == ffmq_pkg::ST_EMIT && emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_size_r   <= res_size_nxt;
    if (in_fire) begin
      wanted_r <= in_wanted;
      seats_r  <= in_seats;
    end
    if (state_r == ffmq_pkg::ST_EMIT && emit_go) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_size_r   <= res_size_r;
      out_occ_r    <= occ_ext[OCC_W-1:0];
    end
  end

  // slot store: append at tail, close the gap on removal
  always_ff @(posedge clk) begin
    if (push_wr) begin
      slot_id_r[count_r[IDX_W-1:0]]   <= in_entry_id;
      slot_size_r[count_r[IDX_W-1:0]] <= in_entry_size;
    end else if (state_r == ffmq_pkg::ST_SCAN && scan_hit) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        if (CNT_W'(k) >= idx_r) begin
          slot_id_r[k]   <= slot_id_r[k+1];
          slot_size_r[k] <= slot_size_r[k+1];
        end
      end
    end
  end

  assign occ_ext    = {{OCC_W{1'b0}}, count_r};
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(ffmq_pkg::OUT_DATA_W - ID_W - SIZE_W - OCC_W){1'b0}},
                       out_occ_r, out_size_r, out_id_r};

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_push && !full) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("accepted push did not grow the queue");

  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffmq_pkg::ST_SCAN) |-> (idx_r <= count_r))
    else $error("scan index past occupancy");

  a_hit_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffmq_pkg::ST_SCAN && scan_hit) |=>
      (count_r == $past(count_r) - CNT_W'(1) && state_r == ffmq_pkg::ST_EMIT))
    else $error("match hit did not remove one entry");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == ffmq_pkg::STAT_OK ||
                     out_status_r == ffmq_pkg::STAT_FULL ||
                     out_status_r == ffmq_pkg::STAT_NONE))
    else $error("illegal result status");
`endif

endmodule
